/* rtl/core/hksp_pkg.sv */
// shared types, constants and keycode table of the keystroke script player
`timescale 1ns / 1ps
`default_nettype none

package hksp_pkg;

  localparam int MAX_STEPS = 4096;
  localparam int MAX_TEXT  = 256;

  localparam int STEP_W     = 13;
  localparam int INTERVAL_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);
  localparam logic [STEP_W-1:0]     STEP_LIMIT     = STEP_W'(MAX_STEPS);
  localparam int TEXT_LIMIT_INT = ((MAX_TEXT - 1) < 255) ? (MAX_TEXT - 1) : 255;
  localparam logic [7:0]            TEXT_LIMIT     = 8'(TEXT_LIMIT_INT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd1;

  // step kinds carried in the mode field
  localparam logic [1:0] MODE_DELAY   = 2'd0;
  localparam logic [1:0] MODE_KEY     = 2'd1;
  localparam logic [1:0] MODE_TEXT    = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [7:0] LEFT_SHIFT = 8'h02;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic        host_ready;
    logic [7:0]  key_code;
    logic [7:0]  key_modifier;
    logic [31:0] delay_ms;
    logic [7:0]  text_char;
    logic        text_end;
  } in_item_t;

  typedef struct packed {
    logic              report_sent;
    logic [7:0]        report_modifier;
    logic [7:0]        report_key;
    logic [STEP_W-1:0] step_index;
    logic [7:0]        char_index;
    logic              script_done;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]     step_count;
    logic [INTERVAL_W-1:0] min_gap_ms;
  } cfg_t;

  // bit 8 is the shift flag, bits 7:0 the keycode
  localparam logic [8:0] ASCII_KEY_ROM [128] = '{
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h02A, 9'h02B, 9'h028, 9'h000, 9'h000, 9'h028, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h000, 9'h029, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h02C, 9'h11E, 9'h134, 9'h120, 9'h121, 9'h122, 9'h124, 9'h034,
    9'h126, 9'h127, 9'h125, 9'h12E, 9'h036, 9'h02D, 9'h037, 9'h038,
    9'h027, 9'h01E, 9'h01F, 9'h020, 9'h021, 9'h022, 9'h023, 9'h024,
    9'h025, 9'h026, 9'h133, 9'h033, 9'h136, 9'h02E, 9'h137, 9'h138,
    9'h11F, 9'h104, 9'h105, 9'h106, 9'h107, 9'h108, 9'h109, 9'h10A,
    9'h10B, 9'h10C, 9'h10D, 9'h10E, 9'h10F, 9'h110, 9'h111, 9'h112,
    9'h113, 9'h114, 9'h115, 9'h116, 9'h117, 9'h118, 9'h119, 9'h11A,
    9'h11B, 9'h11C, 9'h11D, 9'h02F, 9'h031, 9'h030, 9'h123, 9'h12D,
    9'h035, 9'h004, 9'h005, 9'h006, 9'h007, 9'h008, 9'h009, 9'h00A,
    9'h00B, 9'h00C, 9'h00D, 9'h00E, 9'h00F, 9'h010, 9'h011, 9'h012,
    9'h013, 9'h014, 9'h015, 9'h016, 9'h017, 9'h018, 9'h019, 9'h01A,
    9'h01B, 9'h01C, 9'h01D, 9'h12F, 9'h131, 9'h130, 9'h135, 9'h04C
  };

endpackage

`default_nettype wire

/* rtl/core/hksp_cfg_regs.sv */
// configuration registers of the keystroke script player
`timescale 1ns / 1ps
`default_nettype none

module hksp_cfg_regs
  import hksp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [STEP_W-1:0]     step_count_q;
  logic [INTERVAL_W-1:0] interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= '0;
      interval_q   <= INTERVAL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEP_COUNT:    step_count_q <= cfg_data_i[STEP_W-1:0];
        REG_POLL_INTERVAL: interval_q   <= cfg_data_i[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{step_count: step_count_q, min_gap_ms: interval_q};

endmodule

`default_nettype wire

/* rtl/core/hksp_core.sv */
// player state and per-poll decision logic
`timescale 1ns / 1ps
`default_nettype none

module hksp_core
  import hksp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     result_o
);

  logic [31:0]       last_poll_q, last_poll_d;
  logic [31:0]       delay_begin_q, delay_begin_d;
  logic              key_held_q, key_held_d;
  logic              delay_running_q, delay_running_d;
  logic [7:0]        text_pos_q, text_pos_d;
  logic [STEP_W-1:0] step_pos_q, step_pos_d;

  logic [STEP_W-1:0] eff_count;
  logic [31:0]       poll_delta;
  logic [31:0]       delay_delta;
  logic              act;
  logic [8:0]        rom_entry;

  assign eff_count   = (cfg_i.step_count > STEP_LIMIT) ? STEP_LIMIT : cfg_i.step_count;
  assign poll_delta  = item_i.now_ms - last_poll_q;
  assign delay_delta = item_i.now_ms - delay_begin_q;
  assign rom_entry   = ASCII_KEY_ROM[item_i.text_char[6:0]];
  assign act = (step_pos_q < eff_count) && item_i.host_ready &&
               (poll_delta >= {{(32-INTERVAL_W){1'b0}}, cfg_i.min_gap_ms});

  always_comb begin
    last_poll_d     = last_poll_q;
    delay_begin_d   = delay_begin_q;
    key_held_d      = key_held_q;
    delay_running_d = delay_running_q;
    text_pos_d      = text_pos_q;
    step_pos_d      = step_pos_q;
    result_o        = '0;

    if (item_i.mode == MODE_RESTART) begin
      step_pos_d      = '0;
      text_pos_d      = '0;
      key_held_d      = 1'b0;
      delay_running_d = 1'b0;
    end else if (act) begin
      last_poll_d = item_i.now_ms;
      case (item_i.mode)
        MODE_DELAY: begin
          if (!delay_running_q) begin
            delay_begin_d   = item_i.now_ms;
            delay_running_d = 1'b1;
          end else if (delay_delta >= item_i.delay_ms) begin
            delay_running_d = 1'b0;
            step_pos_d      = step_pos_q + 1'b1;
          end
        end
        MODE_KEY: begin
          result_o.report_sent = 1'b1;
          if (!key_held_q) begin
            result_o.report_modifier = item_i.key_modifier;
            result_o.report_key      = item_i.key_code;
            key_held_d               = 1'b1;
          end else begin
            key_held_d = 1'b0;
            step_pos_d = step_pos_q + 1'b1;
          end
        end
        default: begin
          // text step
          if (item_i.text_end) begin
            text_pos_d = '0;
            step_pos_d = step_pos_q + 1'b1;
          end else if (!key_held_q) begin
            result_o.report_sent     = 1'b1;
            result_o.report_modifier = rom_entry[8] ? LEFT_SHIFT : 8'h00;
            result_o.report_key      = rom_entry[7:0];
            key_held_d               = 1'b1;
          end else begin
            result_o.report_sent = 1'b1;
            key_held_d           = 1'b0;
            if (text_pos_q < TEXT_LIMIT) text_pos_d = text_pos_q + 1'b1;
          end
        end
      endcase
    end

    result_o.step_index  = step_pos_d;
    result_o.char_index  = text_pos_d;
    result_o.script_done = (step_pos_d >= eff_count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q     <= '0;
      delay_begin_q   <= '0;
      key_held_q      <= 1'b0;
      delay_running_q <= 1'b0;
      text_pos_q      <= '0;
      step_pos_q      <= '0;
    end else if (advance_i) begin
      last_poll_q     <= last_poll_d;
      delay_begin_q   <= delay_begin_d;
      key_held_q      <= key_held_d;
      delay_running_q <= delay_running_d;
      text_pos_q      <= text_pos_d;
      step_pos_q      <= step_pos_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hid_keystroke_script_player_top.sv */
// top level of the keystroke script player: input register, core, result register
`timescale 1ns / 1ps
`default_nettype none

// Keystroke script player. Each input transaction is one poll carrying the time,
// the host ready flag and the fields of the step at step_index; each poll gives
// exactly one result transaction with the report (press, release or none) and
// the next step and character positions to present. A poll passes through an
// input register, combinational decision logic against the player state, and a
// result register, so the block takes one poll per cycle while the result side
// is not stalled; the state update done as a poll enters the result register sets that rate.
// Stalls on the result side back up into the input register. Configuration
// writes (index 0 step_count, 1 min_gap_ms) are always accepted and must
// be made while no poll is in flight.
module hid_keystroke_script_player_top
  import hksp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire in_item_t              in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      out_valid_q;
  logic      out_free;
  logic      advance;

  assign cfg_ready_o = 1'b1;

  hksp_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  hksp_core u_core (
    .clk_i,
    .rst_ni,
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* test/hid_keystroke_script_player_top_tb.sv */
// testbench of the keystroke script player: scripted polls checked against a predictor
`timescale 1ns / 1ps

module hid_keystroke_script_player_top_tb;
  import hksp_pkg::*;

  localparam int SCRIPT_LEN = 16;
  localparam int TEXT_BUF   = 300;
  localparam int LONG_TEXT  = 270;

  // predicts the report and positions of every accepted poll
  class report_scoreboard;
    logic [STEP_W-1:0]     step_count;
    logic [INTERVAL_W-1:0] poll_interval;
    logic [31:0]           last_poll_ms;
    logic [31:0]           delay_begin_ms;
    bit                    key_held;
    bit                    delay_running;
    logic [7:0]            text_pos;
    logic [STEP_W-1:0]     step_pos;
    logic [8:0]            key_map [128];
    out_item_t             expected_reports [$];
    int                    errors;

    function new();
      // bit 8 asks for left shift
      key_map = '{
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h02A, 9'h02B, 9'h028, 9'h000, 9'h000, 9'h028, 9'h000, 9'h000,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h000, 9'h000, 9'h000, 9'h029, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h02C, 9'h11E, 9'h134, 9'h120, 9'h121, 9'h122, 9'h124, 9'h034,
        9'h126, 9'h127, 9'h125, 9'h12E, 9'h036, 9'h02D, 9'h037, 9'h038,
        9'h027, 9'h01E, 9'h01F, 9'h020, 9'h021, 9'h022, 9'h023, 9'h024,
        9'h025, 9'h026, 9'h133, 9'h033, 9'h136, 9'h02E, 9'h137, 9'h138,
        9'h11F, 9'h104, 9'h105, 9'h106, 9'h107, 9'h108, 9'h109, 9'h10A,
        9'h10B, 9'h10C, 9'h10D, 9'h10E, 9'h10F, 9'h110, 9'h111, 9'h112,
        9'h113, 9'h114, 9'h115, 9'h116, 9'h117, 9'h118, 9'h119, 9'h11A,
        9'h11B, 9'h11C, 9'h11D, 9'h02F, 9'h031, 9'h030, 9'h123, 9'h12D,
        9'h035, 9'h004, 9'h005, 9'h006, 9'h007, 9'h008, 9'h009, 9'h00A,
        9'h00B, 9'h00C, 9'h00D, 9'h00E, 9'h00F, 9'h010, 9'h011, 9'h012,
        9'h013, 9'h014, 9'h015, 9'h016, 9'h017, 9'h018, 9'h019, 9'h01A,
        9'h01B, 9'h01C, 9'h01D, 9'h12F, 9'h131, 9'h130, 9'h135, 9'h04C
      };
      step_count     = '0;
      poll_interval  = INTERVAL_RESET;
      last_poll_ms   = '0;
      delay_begin_ms = '0;
      key_held       = 1'b0;
      delay_running  = 1'b0;
      text_pos       = '0;
      step_pos       = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEP_COUNT:    step_count = data;
        REG_POLL_INTERVAL: poll_interval = data[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit script_done();
      int unsigned steps;
      steps = (step_count > MAX_STEPS) ? MAX_STEPS : step_count;
      return step_pos >= steps;
    endfunction

    // returns 1 when the poll changed the player state
    function bit note_poll(in_item_t p);
      out_item_t   r;
      bit          acted;
      logic [8:0]  entry;
      logic [31:0] since;
      logic [31:0] waited;
      int          text_max;
      r        = '0;
      acted    = 1'b0;
      text_max = (MAX_TEXT - 1 < 255) ? MAX_TEXT - 1 : 255;
      since    = p.now_ms - last_poll_ms;
      waited   = p.now_ms - delay_begin_ms;
      if (p.mode == MODE_RESTART) begin
        step_pos      = '0;
        text_pos      = '0;
        key_held      = 1'b0;
        delay_running = 1'b0;
        acted         = 1'b1;
      end else if (!script_done() && since >= 32'(poll_interval) && p.host_ready) begin
        acted        = 1'b1;
        last_poll_ms = p.now_ms;
        case (p.mode)
          MODE_DELAY: begin
            if (!delay_running) begin
              delay_begin_ms = p.now_ms;
              delay_running  = 1'b1;
            end else if (waited >= p.delay_ms) begin
              delay_running = 1'b0;
              step_pos++;
            end
          end
          MODE_KEY: begin
            r.report_sent = 1'b1;
            if (!key_held) begin
              r.report_modifier = p.key_modifier;
              r.report_key      = p.key_code;
              key_held          = 1'b1;
            end else begin
              key_held = 1'b0;
              step_pos++;
            end
          end
          default: begin
            if (p.text_end) begin
              text_pos = '0;
              step_pos++;
            end else if (!key_held) begin
              entry             = key_map[p.text_char[6:0]];
              r.report_sent     = 1'b1;
              r.report_modifier = entry[8] ? LEFT_SHIFT : 8'h00;
              r.report_key      = entry[7:0];
              key_held          = 1'b1;
            end else begin
              r.report_sent = 1'b1;
              key_held      = 1'b0;
              if (text_pos < text_max) text_pos++;
            end
          end
        endcase
      end
      r.step_index  = step_pos;
      r.char_index  = text_pos;
      r.script_done = script_done();
      expected_reports.push_back(r);
      return acted;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $error("report transaction with none expected: 0x%0h", got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("report_sent", 32'(want.report_sent), 32'(got.report_sent));
      compare_field("report_modifier", 32'(want.report_modifier), 32'(got.report_modifier));
      compare_field("report_key", 32'(want.report_key), 32'(got.report_key));
      compare_field("step_index", 32'(want.step_index), 32'(got.step_index));
      compare_field("char_index", 32'(want.char_index), 32'(got.char_index));
      compare_field("script_done", 32'(want.script_done), 32'(got.script_done));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cfg_ready;

  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          noise_pct     = 0;
  int          restart_pct   = 0;
  logic [31:0] clock_ms      = '0;

  // the script the host would present, indexed by step position
  logic [1:0]  step_kind [SCRIPT_LEN];
  logic [7:0]  step_code [SCRIPT_LEN];
  logic [7:0]  step_mod  [SCRIPT_LEN];
  logic [31:0] step_wait [SCRIPT_LEN];
  int          step_len  [SCRIPT_LEN];
  logic [7:0]  step_text [SCRIPT_LEN][TEXT_BUF];

  report_scoreboard sb = new();

  hid_keystroke_script_player_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_report(out_data);
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // registers change only with no poll in flight
  task automatic configure(input logic [CFG_DATA_W-1:0] steps, input int unsigned ival);
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_STEP_COUNT, steps);
    write_reg(REG_POLL_INTERVAL, CFG_DATA_W'(ival));
  endtask

  task automatic send_poll(input in_item_t p, output bit acted);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    acted = sb.note_poll(p);
    @(negedge clk);
  endtask

  task automatic direct_poll(input logic [1:0] mode, input logic [31:0] dt, input logic ready,
                             input logic [7:0] code, input logic [7:0] modifier,
                             input logic [31:0] wait_ms, input logic [7:0] ch,
                             input logic tend);
    in_item_t p;
    bit       acted;
    clock_ms += dt;
    p.mode         = mode;
    p.now_ms       = clock_ms;
    p.host_ready   = ready;
    p.key_code     = code;
    p.key_modifier = modifier;
    p.delay_ms     = wait_ms;
    p.text_char    = ch;
    p.text_end     = tend;
    send_poll(p, acted);
  endtask

  // mostly one interval on, sometimes too early or far off
  function automatic logic [31:0] advance_clock();
    int unsigned pick;
    logic [31:0] ival;
    ival = 32'(sb.poll_interval);
    pick = $urandom_range(99);
    if (pick < 65) clock_ms += ival + $urandom_range(2);
    else if (pick < 82) clock_ms += $urandom_range(ival);
    else if (pick < 92) clock_ms += $urandom;
    else clock_ms += ival * $urandom_range(3);
    return clock_ms;
  endfunction

  task automatic build_script(input bit with_long_text);
    int unsigned pick;
    logic [31:0] ival;
    ival = 32'(sb.poll_interval);
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      pick = $urandom_range(2);
      step_kind[i] = (pick == 0) ? MODE_DELAY : (pick == 1) ? MODE_KEY : MODE_TEXT;
      step_code[i] = 8'($urandom);
      step_mod[i]  = 8'($urandom);
      pick = $urandom_range(9);
      step_wait[i] = (pick == 0) ? $urandom : (pick < 3) ? 32'd0 : $urandom_range(3 * ival);
      step_len[i]  = $urandom_range(8);
      for (int j = 0; j < TEXT_BUF; j++) step_text[i][j] = 8'($urandom);
    end
    // long enough to run the text position into saturation
    if (with_long_text) begin
      step_kind[1] = MODE_TEXT;
      step_len[1]  = LONG_TEXT;
    end
  endtask

  function automatic in_item_t make_poll();
    in_item_t    p;
    logic [95:0] raw;
    int unsigned pick;
    int unsigned slot;
    raw      = {$urandom, $urandom, $urandom};
    p        = raw[$bits(in_item_t)-1:0];
    pick     = $urandom_range(99);
    p.now_ms = advance_clock();
    if ((sb.script_done() && pick < 80) || pick < restart_pct) begin
      p.mode = MODE_RESTART;
      return p;
    end
    if (pick >= 100 - noise_pct) return p;
    slot           = sb.step_pos % SCRIPT_LEN;
    p.mode         = step_kind[slot];
    p.host_ready   = ($urandom_range(99) < 90);
    p.key_code     = step_code[slot];
    p.key_modifier = step_mod[slot];
    p.delay_ms     = step_wait[slot];
    p.text_end     = (sb.text_pos >= step_len[slot]);
    if (!p.text_end) p.text_char = step_text[slot][sb.text_pos];
    return p;
  endfunction

  task automatic run_phase(input int unsigned target, input logic [CFG_DATA_W-1:0] steps,
                           input int unsigned ival, input int in_idle, input int out_stall,
                           input int noise, input int restarts, input bit long_text);
    int unsigned active_polls;
    bit          acted;
    in_item_t    p;
    configure(steps, ival);
    in_idle_pct   = in_idle;
    out_stall_pct = out_stall;
    noise_pct     = noise;
    restart_pct   = restarts;
    build_script(long_text);
    active_polls = 0;
    while (active_polls < target) begin
      p = make_poll();
      send_poll(p, acted);
      if (acted) active_polls++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty script does nothing
    write_reg(REG_STEP_COUNT, '0);
    direct_poll(MODE_KEY, 100, 1'b1, 8'hFF, 8'hFF, '0, '0, 1'b0);

    // oversized step count, 1000 ms pacing
    configure(13'h1FFF, 1000);
    direct_poll(MODE_KEY, 400, 1'b1, 8'hFF, 8'hFF, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 500, 1'b0, 8'hFF, 8'hFF, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 0, 1'b1, 8'hFF, 8'hFF, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 999, 1'b1, 8'hFF, 8'hFF, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 1, 1'b1, 8'hFF, 8'hFF, '0, '0, 1'b0);
    // millisecond counter wraps between press and release
    direct_poll(MODE_TEXT, 32'hFFFF_F730, 1'b1, '0, '0, '0, 8'h41, 1'b0);
    direct_poll(MODE_TEXT, 1000, 1'b1, '0, '0, '0, 8'h41, 1'b0);
    direct_poll(MODE_TEXT, 1000, 1'b1, '0, '0, '0, 8'hE1, 1'b0);
    direct_poll(MODE_TEXT, 1000, 1'b1, '0, '0, '0, 8'hE1, 1'b0);
    direct_poll(MODE_TEXT, 1000, 1'b1, '0, '0, '0, 8'h7F, 1'b0);
    // text end while the key is still down
    direct_poll(MODE_TEXT, 1000, 1'b1, '0, '0, '0, '0, 1'b1);
    direct_poll(MODE_DELAY, 1000, 1'b1, '0, '0, 32'd0, '0, 1'b0);
    direct_poll(MODE_DELAY, 1000, 1'b1, '0, '0, 32'd0, '0, 1'b0);
    // key step inherits the held key and only releases
    direct_poll(MODE_KEY, 1000, 1'b1, 8'h12, 8'h34, '0, '0, 1'b0);
    direct_poll(MODE_DELAY, 1000, 1'b1, '0, '0, 32'hFFFF_FFFF, '0, 1'b0);
    direct_poll(MODE_DELAY, 1000, 1'b1, '0, '0, 32'hFFFF_FFFF, '0, 1'b0);
    direct_poll(MODE_RESTART, 0, 1'b0, '0, '0, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 1000, 1'b1, 8'h00, 8'h00, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 1000, 1'b1, 8'h00, 8'h00, '0, '0, 1'b0);
    direct_poll(MODE_TEXT, 1000, 1'b1, '0, '0, '0, 8'h00, 1'b0);

    // no pacing, one step script
    configure(13'd1, 0);
    direct_poll(MODE_TEXT, 0, 1'b1, '0, '0, '0, 8'h20, 1'b0);
    direct_poll(MODE_RESTART, 0, 1'b1, '0, '0, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 0, 1'b1, 8'h5A, 8'h81, '0, '0, 1'b0);
    direct_poll(MODE_KEY, 0, 1'b1, 8'h5A, 8'h81, '0, '0, 1'b0);

    run_phase(540, 13'h1FFF, 0, 0, 0, 0, 0, 1'b1);
    run_phase(30, 13'd5, 1000, 82, 0, 8, 4, 1'b0);
    clock_ms = 32'hFFFF_F000;
    run_phase(30, 13'd4096, 1, 0, 82, 8, 4, 1'b0);
    run_phase(30, 13'd3, 1023, 30, 30, 8, 4, 1'b0);

    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* hid_keystroke_script_player_top.f */
rtl/core/hksp_pkg.sv
rtl/core/hksp_cfg_regs.sv
rtl/core/hksp_core.sv
rtl/core/hid_keystroke_script_player_top.sv
test/hid_keystroke_script_player_top_tb.sv
